/* design/btpc_pkg.sv */
// ------------------------------------------------------------------------------------------
// btpc_pkg: shared types and constants for the barometric compensation pipeline
// Field widths, calibration register set, register indexes and stage payload structs.
// ------------------------------------------------------------------------------------------
package btpc_pkg;

	// Port field widths
	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int IDX_W   = 3;
	localparam int TOUT_W  = 21;
	localparam int POUT_W  = 32;

	// Internal value widths, sized for the full input and register space
	localparam int DT_W    = 25;  // D2 - C5*256
	localparam int TEMP_W  = 19;  // first-order temperature
	localparam int T_W     = 20;  // corrected temperature
	localparam int OFF_W   = 36;  // first-order offset
	localparam int SENS_W  = 35;  // first-order sensitivity
	localparam int T2H_W   = 13;  // high-temperature T2
	localparam int T2L_W   = 17;  // low-temperature T2
	localparam int TXSQ_W  = 34;  // (TEMP-2000)^2
	localparam int TYSQ_W  = 36;  // (TEMP+1500)^2
	localparam int OFFC_W  = 44;  // offset after second-order correction
	localparam int SENSC_W = 43;  // sensitivity after second-order correction
	localparam int SLO_W   = 22;  // low part of the split sensitivity
	localparam int SHI_W   = SENSC_W - SLO_W;
	localparam int T9_W    = 22;  // magnitude of 9*T
	localparam int PX_W    = 47;  // D1*SENS/2^21

	// Compensation constants
	localparam int TEMP_REF      = 2000;
	localparam int TEMP_VERY_LOW = -1500;
	localparam int F_OFFSET      = 3200;
	// ceil(2^26/5): exact quotient by five for magnitudes below 2^22
	localparam logic [23:0] RECIP5 = 24'd13421773;
	localparam int RECIP5_SH = 26;

	// Pipeline depth, one word per stage
	localparam int PIPE_DEPTH = 8;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CAL_SENS          = 3'd0,
		REG_CAL_OFFSET        = 3'd1,
		REG_CAL_SENS_TEMPCO   = 3'd2,
		REG_CAL_OFFSET_TEMPCO = 3'd3,
		REG_CAL_REF_TEMP      = 3'd4,
		REG_CAL_TEMP_COEFF    = 3'd5,
		REG_FAHRENHEIT_MODE   = 3'd6
	} reg_idx_t;

	// Calibration set
	typedef struct packed {
		logic [CAL_W-1:0] cal_sens;
		logic [CAL_W-1:0] cal_offset;
		logic [CAL_W-1:0] cal_sens_tempco;
		logic [CAL_W-1:0] cal_offset_tempco;
		logic [CAL_W-1:0] cal_ref_temp;
		logic [CAL_W-1:0] cal_temp_coeff;
		logic             fahrenheit_mode;
	} cal_t;

	// First-order results
	typedef struct packed {
		logic        [RAW_W-1:0]  d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic        [T2H_W-1:0]  t2_hi;
		logic        [T2L_W-1:0]  t2_lo;
	} fo_t;

	// Second-order results
	typedef struct packed {
		logic        [RAW_W-1:0]   d1;
		logic signed [OFFC_W-1:0]  off_c;
		logic signed [SENSC_W-1:0] sens_c;
		logic signed [T_W-1:0]     t;
		logic                      t9_neg;
		logic        [T9_W-1:0]    t9_mag;
	} so_t;

endpackage

/* design/btpc_if.sv */
// ------------------------------------------------------------------------------------------
// btpc_if: channel interfaces
// Raw sample channel, result channel and configuration write channel, valid/ready each.
// ------------------------------------------------------------------------------------------
interface btpc_in_if;
	import btpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface btpc_out_if;
	import btpc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TOUT_W-1:0] temperature_out;
	logic signed [POUT_W-1:0] pressure_out;
	modport source (output valid, output temperature_out, output pressure_out, input ready);
	modport sink (input valid, input temperature_out, input pressure_out, output ready);
endinterface

interface btpc_cfg_if;
	import btpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CAL_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/btpc_cfg_regs.sv */
// ------------------------------------------------------------------------------------------
// btpc_cfg_regs: calibration register file
// Takes one write word per cycle and holds the six calibration words and the unit mode.
// ------------------------------------------------------------------------------------------
module btpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	input  logic [btpc_pkg::IDX_W-1:0]     wr_index,
	input  logic [btpc_pkg::CAL_W-1:0]     wr_data,
	output logic                           wr_ready,
	output btpc_pkg::cal_t                 cal
);
	import btpc_pkg::*;

	cal_t cal_q;

	assign wr_ready = 1'b1;
	assign cal      = cal_q;

	// Write the addressed register, drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_valid) begin
			case (reg_idx_t'(wr_index))
				REG_CAL_SENS:          cal_q.cal_sens          <= wr_data;
				REG_CAL_OFFSET:        cal_q.cal_offset        <= wr_data;
				REG_CAL_SENS_TEMPCO:   cal_q.cal_sens_tempco   <= wr_data;
				REG_CAL_OFFSET_TEMPCO: cal_q.cal_offset_tempco <= wr_data;
				REG_CAL_REF_TEMP:      cal_q.cal_ref_temp      <= wr_data;
				REG_CAL_TEMP_COEFF:    cal_q.cal_temp_coeff    <= wr_data;
				REG_FAHRENHEIT_MODE:   cal_q.fahrenheit_mode   <= wr_data[0];
				default: ;
			endcase
		end
	end

endmodule

/* design/btpc_first_order.sv */
// ------------------------------------------------------------------------------------------
// btpc_first_order: stages 1 to 3
// dT, the calibration products, then first-order TEMP, OFF, SENS and both T2 candidates.
// ------------------------------------------------------------------------------------------
module btpc_first_order (
	input  logic                       clk,
	input  logic                       arst_n,
	input  btpc_pkg::cal_t             cal,
	input  logic                       in_valid,
	input  logic [btpc_pkg::RAW_W-1:0] raw_pressure,
	input  logic [btpc_pkg::RAW_W-1:0] raw_temperature,
	output logic                       in_ready,
	output logic                       out_valid,
	output btpc_pkg::fo_t              out_data,
	input  logic                       out_ready
);
	import btpc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic        [RAW_W-1:0]  d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [41:0]       dtc6_s2, c4dt_s2, c3dt_s2;
	logic        [47:0]       dtsq_s2;
	fo_t                      fo_s3;

	logic signed [49:0]       dtsq_full;
	logic signed [41:0]       q_temp, q_off, q_sens;
	logic        [50:0]       dtsq5;
	logic        [49:0]       dtsq3;
	fo_t                      fo_next;

	// Advance a stage when it is empty or the next one moves
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s3;
	assign out_data  = fo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: dT
	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.cal_ref_temp, 8'h00});
		end
	end

	// Stage 2: calibration products and dT squared
	assign dtsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, cal.cal_temp_coeff});
			c4dt_s2 <= dt_s1 * $signed({1'b0, cal.cal_offset_tempco});
			c3dt_s2 <= dt_s1 * $signed({1'b0, cal.cal_sens_tempco});
			dtsq_s2 <= dtsq_full[47:0];
		end
	end

	// Stage 3: truncate toward zero, add base terms, scale the squares
	always_comb begin
		q_temp = (dtc6_s2 + (dtc6_s2[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
		q_off  = (c4dt_s2 + (c4dt_s2[41] ? 42'sd63 : 42'sd0)) >>> 6;
		q_sens = (c3dt_s2 + (c3dt_s2[41] ? 42'sd127 : 42'sd0)) >>> 7;
		dtsq5  = {1'b0, dtsq_s2, 2'b00} + {3'b000, dtsq_s2};
		dtsq3  = {1'b0, dtsq_s2, 1'b0} + {2'b00, dtsq_s2};

		fo_next.d1    = d1_s2;
		fo_next.temp  = TEMP_W'(TEMP_REF) + q_temp[TEMP_W-1:0];
		fo_next.off   = $signed({3'b000, cal.cal_offset, 17'h00000}) + q_off[OFF_W-1:0];
		fo_next.sens  = $signed({3'b000, cal.cal_sens, 16'h0000}) + q_sens[SENS_W-1:0];
		fo_next.t2_hi = dtsq5[50:38];
		fo_next.t2_lo = dtsq3[49:33];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			fo_s3 <= fo_next;
		end
	end

endmodule

/* design/btpc_second_order.sv */
// ------------------------------------------------------------------------------------------
// btpc_second_order: stages 4 and 5
// Region choice, temperature squares, OFF2/SENS2 and the corrected offset and sensitivity.
// ------------------------------------------------------------------------------------------
module btpc_second_order (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  btpc_pkg::fo_t  in_data,
	output logic           in_ready,
	output logic           out_valid,
	output btpc_pkg::so_t  out_data,
	input  logic           out_ready
);
	import btpc_pkg::*;

	logic v_s4, v_s5;
	logic en_s4, en_s5;

	logic        [RAW_W-1:0]  d1_s4;
	logic signed [OFF_W-1:0]  off_s4;
	logic signed [SENS_W-1:0] sens_s4;
	logic                     low_s4, vlow_s4;
	logic        [TXSQ_W-1:0] txsq_s4;
	logic        [TYSQ_W-1:0] tysq_s4;
	logic signed [T_W-1:0]    t_s4;
	so_t                      so_s5;

	logic signed [T_W-1:0]    tx, ty, t_next;
	logic signed [39:0]       tx_sq, ty_sq;
	logic        [39:0]       tx61;
	logic        [38:0]       tx29;
	logic        [40:0]       ty17;
	logic        [39:0]       ty9;
	logic        [41:0]       off2;
	logic        [40:0]       sens2;
	logic signed [23:0]       t9;
	logic        [23:0]       t9_abs;
	so_t                      so_next;

	assign en_s5     = !v_s5 || out_ready;
	assign en_s4     = !v_s4 || en_s5;
	assign in_ready  = en_s4;
	assign out_valid = v_s5;
	assign out_data  = so_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 4: pick region by first-order TEMP, square the distances
	always_comb begin
		tx     = T_W'(in_data.temp) - T_W'(TEMP_REF);
		ty     = T_W'(in_data.temp) - T_W'(TEMP_VERY_LOW);
		tx_sq  = tx * tx;
		ty_sq  = ty * ty;
		t_next = T_W'(in_data.temp) - ((in_data.temp < TEMP_W'(TEMP_REF)) ?
			$signed({3'b000, in_data.t2_lo}) : $signed({7'b0000000, in_data.t2_hi}));
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4   <= in_data.d1;
			off_s4  <= in_data.off;
			sens_s4 <= in_data.sens;
			low_s4  <= in_data.temp < TEMP_W'(TEMP_REF);
			vlow_s4 <= in_data.temp < TEMP_W'(TEMP_VERY_LOW);
			txsq_s4 <= tx_sq[TXSQ_W-1:0];
			tysq_s4 <= ty_sq[TYSQ_W-1:0];
			t_s4    <= t_next;
		end
	end

	// Stage 5: OFF2 and SENS2 by shift and add, corrected terms, 9*T magnitude
	always_comb begin
		tx61  = {txsq_s4, 6'h00} - {5'h00, txsq_s4, 1'b0} - {6'h00, txsq_s4};
		tx29  = {txsq_s4, 5'h00} - {4'h0, txsq_s4, 1'b0} - {5'h00, txsq_s4};
		ty17  = {1'b0, tysq_s4, 4'h0} + {5'h00, tysq_s4};
		ty9   = {1'b0, tysq_s4, 3'h0} + {4'h0, tysq_s4};
		off2  = {6'h00, tx61[39:4]} + (vlow_s4 ? {1'b0, ty17} : 42'd0);
		sens2 = {6'h00, tx29[38:4]} + (vlow_s4 ? {1'b0, ty9} : 41'd0);
		if (!low_s4) begin
			off2  = '0;
			sens2 = '0;
		end
		t9     = (24'(t_s4) <<< 3) + 24'(t_s4);
		t9_abs = t9[23] ? 24'(-t9) : 24'(t9);

		so_next.d1     = d1_s4;
		so_next.off_c  = OFFC_W'(off_s4) - $signed({2'b00, off2});
		so_next.sens_c = SENSC_W'(sens_s4) - $signed({2'b00, sens2});
		so_next.t      = t_s4;
		so_next.t9_neg = t9[23];
		so_next.t9_mag = t9_abs[T9_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			so_s5 <= so_next;
		end
	end

endmodule

/* design/btpc_output.sv */
// ------------------------------------------------------------------------------------------
// btpc_output: stages 6 to 8
// Split D1*SENS product, Fahrenheit scaling, final pressure division and saturation.
// ------------------------------------------------------------------------------------------
module btpc_output (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  btpc_pkg::cal_t                       cal,
	input  logic                                 in_valid,
	input  btpc_pkg::so_t                        in_data,
	output logic                                 in_ready,
	output logic                                 out_valid,
	output logic signed [btpc_pkg::TOUT_W-1:0]   temperature_out,
	output logic signed [btpc_pkg::POUT_W-1:0]   pressure_out,
	input  logic                                 out_ready
);
	import btpc_pkg::*;

	localparam int PROD_W = RAW_W + SENSC_W + 1;
	localparam int Y_W    = PX_W + 1;

	logic v_s6, v_s7, v_s8;
	logic en_s6, en_s7, en_s8;

	logic        [RAW_W+SLO_W-1:0]   pp_lo_s6;
	logic signed [RAW_W+SHI_W:0]     pp_hi_s6;
	logic signed [OFFC_W-1:0]        off_s6, off_s7;
	logic        [45:0]              fq_s6;
	logic                            neg_s6;
	logic signed [T_W-1:0]           t_s6;
	logic signed [PX_W-1:0]          px_s7;
	logic signed [TOUT_W-1:0]        tout_s7;

	logic signed [PROD_W-1:0]        prod;
	logic signed [PROD_W-1:0]        prod_sh;
	logic signed [TOUT_W-1:0]        fq, ftemp;
	logic signed [Y_W-1:0]           y, y_sh;
	logic signed [Y_W-1:0]           p;

	assign en_s8     = !v_s8 || out_ready;
	assign en_s7     = !v_s7 || en_s8;
	assign en_s6     = !v_s6 || en_s7;
	assign in_ready  = en_s6;
	assign out_valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// Stage 6: partial products of D1*SENS and the reciprocal multiply for /5
	always_ff @(posedge clk) begin
		if (en_s6) begin
			pp_lo_s6 <= in_data.d1 * in_data.sens_c[SLO_W-1:0];
			pp_hi_s6 <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens_c[SENSC_W-1:SLO_W]);
			fq_s6    <= in_data.t9_mag * RECIP5;
			off_s6   <= in_data.off_c;
			neg_s6   <= in_data.t9_neg;
			t_s6     <= in_data.t;
		end
	end

	// Stage 7: merge partial products, divide by 2^21, finish the temperature word
	always_comb begin
		prod    = (PROD_W'(pp_hi_s6) <<< SLO_W) + $signed({{(PROD_W-RAW_W-SLO_W){1'b0}}, pp_lo_s6});
		prod_sh = (prod + (prod[PROD_W-1] ? PROD_W'(2097151) : PROD_W'(0))) >>> 21;
		fq      = $signed({1'b0, fq_s6[45:RECIP5_SH]});
		ftemp   = (neg_s6 ? -fq : fq) + TOUT_W'(F_OFFSET);
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			px_s7   <= prod_sh[PX_W-1:0];
			off_s7  <= off_s6;
			tout_s7 <= cal.fahrenheit_mode ? ftemp : TOUT_W'(t_s6);
		end
	end

	// Stage 8: subtract offset, divide by 2^15, saturate to 32 bits
	always_comb begin
		y    = Y_W'(px_s7) - Y_W'(off_s7);
		y_sh = (y + (y[Y_W-1] ? Y_W'(32767) : Y_W'(0))) >>> 15;
		p    = y_sh;
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			temperature_out <= tout_s7;
			if (p > Y_W'(32'sh7FFFFFFF)) begin
				pressure_out <= 32'sh7FFFFFFF;
			end else if (p < -Y_W'(33'sh080000000)) begin
				pressure_out <= 32'sh80000000;
			end else begin
				pressure_out <= p[POUT_W-1:0];
			end
		end
	end

endmodule

/* design/baro_temp_pressure_compensation_top.sv */
// ------------------------------------------------------------------------------------------
// baro_temp_pressure_compensation_top: second-order barometric compensation pipeline
// Raw pressure and temperature words in, compensated temperature and pressure words out.
// ------------------------------------------------------------------------------------------
// Each sample word (raw D1 pressure, raw D2 temperature) yields one result word: temperature
// in hundredths of a degree (Celsius, or Fahrenheit when the mode register is set) and
// pressure in pascals, with the low, very-low and high temperature corrections applied.
// The block is an eight-stage pipeline that takes one word every clock while the result
// side keeps up; each word passes through all eight register stages in order. Stages 2,
// 4 and 6 hold the multipliers, and the wide D1*sensitivity product is split across stages
// 6 and 7. Each stage moves on its own when empty, so bubbles close up under a stalled
// output. Write the seven calibration and mode registers through the configuration channel
// only while no words are in flight.
module baro_temp_pressure_compensation_top (
	input  logic      clk,
	input  logic      arst_n,
	btpc_cfg_if.sink  cfg,
	btpc_in_if.sink   sample,
	btpc_out_if.source result
);
	import btpc_pkg::*;

	cal_t cal;
	logic fo_valid, fo_ready;
	fo_t  fo_data;
	logic so_valid, so_ready;
	so_t  so_data;

	// Calibration registers
	btpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cal      (cal)
	);

	// First-order terms
	btpc_first_order u_first (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (sample.valid),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.in_ready        (sample.ready),
		.out_valid       (fo_valid),
		.out_data        (fo_data),
		.out_ready       (fo_ready)
	);

	// Second-order correction
	btpc_second_order u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fo_valid),
		.in_data   (fo_data),
		.in_ready  (fo_ready),
		.out_valid (so_valid),
		.out_data  (so_data),
		.out_ready (so_ready)
	);

	// Pressure and output words
	btpc_output u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (so_valid),
		.in_data         (so_data),
		.in_ready        (so_ready),
		.out_valid       (result.valid),
		.temperature_out (result.temperature_out),
		.pressure_out    (result.pressure_out),
		.out_ready       (result.ready)
	);

endmodule

/* design/btpc_checker.sv */
// ------------------------------------------------------------------------------------------
// btpc_checker: port-level checks for the compensation pipeline
// Output handshake rules and word accounting between the sample and result channels.
// ------------------------------------------------------------------------------------------
module btpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [btpc_pkg::TOUT_W-1:0]  temperature_out,
	input logic signed [btpc_pkg::POUT_W-1:0]  pressure_out
);
	import btpc_pkg::*;

	logic [3:0] inflight_q;

	// Count words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature_out) && $stable(pressure_out))
		else $error("result word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("result word with no sample word in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (sample.valid),
	.in_ready        (sample.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.temperature_out (result.temperature_out),
	.pressure_out    (result.pressure_out)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// testbench: barometric compensation pipeline regression
// Drives raw pressure/temperature words through the pipeline under several calibration
// sets and both temperature units. A scoreboard class predicts each result word in 64-bit
// integer math and checks the output stream in order. The sender bursts, the receiver
// stalls, and a watchdog ends a run that stops moving.
// ------------------------------------------------------------------------------------------
module testbench;
	import btpc_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 68;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint RAW_MAX = (64'sd1 <<< RAW_W) - 1;
	localparam logic [RAW_W-1:0] RAW_ONES = '1;

	// Scale factors of the compensation formulas
	localparam longint DIV_TEMP  = 64'sd1 <<< 23;
	localparam longint DIV_OFF   = 64'sd1 <<< 6;
	localparam longint DIV_SENS  = 64'sd1 <<< 7;
	localparam longint MUL_OFF   = 64'sd1 <<< 17;
	localparam longint MUL_SENS  = 64'sd1 <<< 16;
	localparam longint DIV_T2_HI = 64'sd1 <<< 38;
	localparam longint DIV_T2_LO = 64'sd1 <<< 33;
	localparam longint DIV_PX    = 64'sd1 <<< 21;
	localparam longint DIV_P     = 64'sd1 <<< 15;
	localparam longint P_MAX     = 64'sd2147483647;
	localparam longint P_MIN     = -64'sd2147483648;

	// Datasheet-like calibration
	localparam cal_t TYPICAL_CAL = '{cal_sens: 16'd46372, cal_offset: 16'd43981,
		cal_sens_tempco: 16'd29059, cal_offset_tempco: 16'd27842, cal_ref_temp: 16'd31553,
		cal_temp_coeff: 16'd28165, fahrenheit_mode: 1'b0};
	// Reference 40000*256 and a coefficient of 2^15 put region edges on round readings
	localparam cal_t EDGE_CAL = '{cal_sens: 16'd46372, cal_offset: 16'd43981,
		cal_sens_tempco: 16'd29059, cal_offset_tempco: 16'd27842, cal_ref_temp: 16'd40000,
		cal_temp_coeff: 16'd32768, fahrenheit_mode: 1'b0};

	// Raw temperatures under EDGE_CAL: TEMP of exactly 2000, 1999, -1500 and -1501,
	// zero and full scale, high side, below reference by one count, two ordinary points
	localparam logic [RAW_W-1:0] EDGE_TEMPS [10] = '{24'd10240000, 24'd10239744,
		24'd9344000, 24'd9343744, 24'd0, 24'd16777215, 24'd10265600, 24'd10239999,
		24'd8077636, 24'd5000000};
	localparam logic [RAW_W-1:0] EDGE_PRESSURES [3] = '{24'd6465444, 24'd0, 24'd16777215};

	typedef struct packed {
		logic signed [TOUT_W-1:0] temperature;
		logic signed [POUT_W-1:0] pressure;
	} reading_t;

	// Predicts compensated readings and checks the result stream in order
	class compensation_scoreboard;
		cal_t     cal;
		reading_t pending_readings[$];
		int       mismatches;

		function new();
			cal = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] value);
			case (idx)
				REG_CAL_SENS:          cal.cal_sens = value;
				REG_CAL_OFFSET:        cal.cal_offset = value;
				REG_CAL_SENS_TEMPCO:   cal.cal_sens_tempco = value;
				REG_CAL_OFFSET_TEMPCO: cal.cal_offset_tempco = value;
				REG_CAL_REF_TEMP:      cal.cal_ref_temp = value;
				REG_CAL_TEMP_COEFF:    cal.cal_temp_coeff = value;
				REG_FAHRENHEIT_MODE:   cal.fahrenheit_mode = value[0];
				default: ;
			endcase
		endfunction

		function reading_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
			longint d1, d2, dt, temp, off, sens, t2, tx, ty, off2, sens2, t_out, p;
			reading_t r;
			d1 = longint'(d1_raw);
			d2 = longint'(d2_raw);
			// first order
			dt   = d2 - longint'(cal.cal_ref_temp) * 256;
			temp = TEMP_REF + (dt * longint'(cal.cal_temp_coeff)) / DIV_TEMP;
			off  = longint'(cal.cal_offset) * MUL_OFF
				+ (longint'(cal.cal_offset_tempco) * dt) / DIV_OFF;
			sens = longint'(cal.cal_sens) * MUL_SENS
				+ (longint'(cal.cal_sens_tempco) * dt) / DIV_SENS;
			// second order, region picked by first-order TEMP
			if (temp >= TEMP_REF) begin
				t2 = 5 * (dt * dt) / DIV_T2_HI;
			end else begin
				tx = (temp - TEMP_REF) * (temp - TEMP_REF);
				t2 = 3 * (dt * dt) / DIV_T2_LO;
				off2 = 61 * tx / 16;
				sens2 = 29 * tx / 16;
				if (temp < TEMP_VERY_LOW) begin
					ty = (temp - TEMP_VERY_LOW) * (temp - TEMP_VERY_LOW);
					off2 += 17 * ty;
					sens2 += 9 * ty;
				end
				off -= off2;
				sens -= sens2;
			end
			t_out = temp - t2;
			if (cal.fahrenheit_mode)
				t_out = t_out * 9 / 5 + F_OFFSET;
			p = (d1 * sens / DIV_PX - off) / DIV_P;
			if (p > P_MAX)
				p = P_MAX;
			if (p < P_MIN)
				p = P_MIN;
			r.temperature = t_out[TOUT_W-1:0];
			r.pressure = p[POUT_W-1:0];
			return r;
		endfunction

		function void note_sample(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
			pending_readings.push_back(compensate(d1, d2));
		endfunction

		function void check_reading(logic signed [TOUT_W-1:0] t, logic signed [POUT_W-1:0] p);
			reading_t want;
			if (pending_readings.size() == 0) begin
				$error("result word with nothing pending: temperature_out %0d pressure_out %0d",
					t, p);
				mismatches++;
				return;
			end
			want = pending_readings.pop_front();
			if (t !== want.temperature) begin
				$error("temperature_out: expected %0d, got %0d", want.temperature, t);
				mismatches++;
			end
			if (p !== want.pressure) begin
				$error("pressure_out: expected %0d, got %0d", want.pressure, p);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   hold_request;
	compensation_scoreboard sb;

	btpc_cfg_if cfg_bus ();
	btpc_in_if  sample_bus ();
	btpc_out_if result_bus ();

	baro_temp_pressure_compensation_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (sample_bus),
		.result (result_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Note accepted sample words and check accepted result words
	always @(posedge clk) begin
		if (sample_bus.valid && sample_bus.ready)
			sb.note_sample(sample_bus.raw_pressure, sample_bus.raw_temperature);
		if (result_bus.valid && result_bus.ready)
			sb.check_reading(result_bus.temperature_out, result_bus.pressure_out);
	end

	// Receiver: hold off on request, otherwise cycle through stall styles
	initial begin : receiver_stalls
		int style, left, held;
		result_bus.ready = 1'b0;
		style = 0;
		left = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_bus.ready <= 1'b0;
				held++;
				if (held == HOLD_CYCLES) begin
					hold_request = 1'b0;
					held = 0;
				end
			end else begin
				if (left == 0) begin
					style = $urandom_range(0, 3);
					left = $urandom_range(8, 64);
				end
				left--;
				case (style)
					0: result_bus.ready <= 1'b1;
					1: result_bus.ready <= ($urandom_range(0, 1) == 1);
					2: result_bus.ready <= ($urandom_range(0, 3) != 0);
					default: result_bus.ready <= (left % 3 == 0);
				endcase
			end
		end
	end

	// Drop the run if no word moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		sample_bus.valid <= 1'b1;
		sample_bus.raw_pressure <= d1;
		sample_bus.raw_temperature <= d2;
		do @(posedge clk); while (!sample_bus.ready);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		sample_bus.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Stop sending and wait for every pending result word
	task automatic drain();
		sample_bus.valid <= 1'b0;
		while (sb.pending_readings.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Write the whole register set, then a word to the unused index
	task automatic load_calibration(input cal_t c);
		logic [CAL_W-1:0] mode_word;
		mode_word = CAL_W'($urandom);
		mode_word[0] = c.fahrenheit_mode;
		write_reg(REG_CAL_SENS, c.cal_sens);
		write_reg(REG_CAL_OFFSET, c.cal_offset);
		write_reg(REG_CAL_SENS_TEMPCO, c.cal_sens_tempco);
		write_reg(REG_CAL_OFFSET_TEMPCO, c.cal_offset_tempco);
		write_reg(REG_CAL_REF_TEMP, c.cal_ref_temp);
		write_reg(REG_CAL_TEMP_COEFF, c.cal_temp_coeff);
		write_reg(REG_FAHRENHEIT_MODE, mode_word);
		write_reg(REG_UNUSED, CAL_W'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_edge_points();
		for (int i = 0; i < 10; i++)
			send_sample(EDGE_PRESSURES[i % 3], EDGE_TEMPS[i]);
	endtask

	// Random words: temperatures spread over full scale, near the reference and below it
	task automatic run_random(input int count, input bit with_gaps);
		int left, burst;
		longint ref_raw, pick;
		logic [RAW_W-1:0] d1, d2;
		left = count;
		while (left > 0) begin
			burst = with_gaps ? $urandom_range(1, 20) : left;
			if (burst > left)
				burst = left;
			repeat (burst) begin
				ref_raw = longint'(sb.cal.cal_ref_temp) * 256;
				case ($urandom_range(0, 4))
					0: pick = ref_raw + int'($urandom_range(0, 8192)) - 4096;
					1: pick = longint'($urandom_range(0, 32'(ref_raw)));
					2: pick = ($urandom_range(0, 1) == 1) ? RAW_MAX : 0;
					default: pick = longint'($urandom_range(0, 32'(RAW_MAX)));
				endcase
				if (pick < 0)
					pick = 0;
				if (pick > RAW_MAX)
					pick = RAW_MAX;
				d2 = pick[RAW_W-1:0];
				if ($urandom_range(0, 15) == 0)
					d1 = ($urandom_range(0, 1) == 1) ? RAW_ONES : '0;
				else
					d1 = RAW_W'($urandom);
				send_sample(d1, d2);
			end
			left -= burst;
			if (with_gaps && $urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin : stimulus
		cal_t c;
		sb = new();
		arst_n = 1'b0;
		hold_request = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.raw_pressure = '0;
		sample_bus.raw_temperature = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_CAL_SENS;
		cfg_bus.data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers still at reset: all calibration zero, Celsius
		send_sample('0, '0);
		send_sample(RAW_ONES, RAW_ONES);
		send_sample(RAW_ONES, '0);
		send_sample('0, RAW_ONES);
		drain();

		// Region edges in both units
		c = EDGE_CAL;
		load_calibration(c);
		send_edge_points();
		drain();
		c.fahrenheit_mode = 1'b1;
		load_calibration(c);
		send_edge_points();
		drain();

		// Random phases, one with the receiver held off while words keep coming
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: c = '1;
				1: c = TYPICAL_CAL;
				6: begin
					c = '0;
					c.fahrenheit_mode = 1'($urandom_range(0, 1));
				end
				default: begin
					c.cal_sens = CAL_W'($urandom);
					c.cal_offset = CAL_W'($urandom);
					c.cal_sens_tempco = CAL_W'($urandom);
					c.cal_offset_tempco = CAL_W'($urandom);
					c.cal_ref_temp = CAL_W'($urandom);
					c.cal_temp_coeff = CAL_W'($urandom);
					c.fahrenheit_mode = 1'($urandom_range(0, 1));
				end
			endcase
			load_calibration(c);
			if (phase == 3)
				hold_request = 1'b1;
			run_random(PHASE_WORDS, phase != 3);
			drain();
		end

		repeat (PIPE_DEPTH * 2) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_readings.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
design/btpc_pkg.sv
design/btpc_if.sv
design/btpc_cfg_regs.sv
design/btpc_first_order.sv
design/btpc_second_order.sv
design/btpc_output.sv
design/baro_temp_pressure_compensation_top.sv
design/btpc_checker.sv
verif/testbench.sv
